>>> rtl/core/mouse_packet_cursor_tracker_macros.svh
// ----------------------------------------------------------------------------
// Mouse packet cursor tracker assertion macros
// Shared concurrent assertion forms used by the tracker modules.
// ----------------------------------------------------------------------------
`ifndef MOUSE_PACKET_CURSOR_TRACKER_MACROS_SVH
`define MOUSE_PACKET_CURSOR_TRACKER_MACROS_SVH

// same-cycle implication, disabled during reset
`define MPCT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define MPCT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/mpct_pkg.sv
// ----------------------------------------------------------------------------
// mpct_pkg
// Types and constants shared by the mouse packet cursor tracker modules.
// ----------------------------------------------------------------------------
package mpct_pkg;

   localparam int unsigned COORD_W = 10;
   localparam int unsigned DELTA_W = 9;

   // byte status codes
   localparam logic [1:0] STAT_IGNORED    = 2'd0;
   localparam logic [1:0] STAT_ACCEPTED   = 2'd1;
   localparam logic [1:0] STAT_HDR_REJECT = 2'd2;
   localparam logic [1:0] STAT_OVERFLOW   = 2'd3;

   // position of the next byte within a packet
   localparam logic [1:0] IDX_HEADER = 2'd0;
   localparam logic [1:0] IDX_XDELTA = 2'd1;
   localparam logic [1:0] IDX_YDELTA = 2'd2;

   // register indexes
   localparam logic CSR_X_MAX = 1'b0;
   localparam logic CSR_Y_MAX = 1'b1;

   // status and header bit positions
   localparam int unsigned STS_FULL_BIT  = 0;
   localparam int unsigned STS_AUX_BIT   = 5;
   localparam int unsigned HDR_SYNC_BIT  = 3;
   localparam int unsigned HDR_XSIGN_BIT = 4;
   localparam int unsigned HDR_YSIGN_BIT = 5;
   localparam int unsigned HDR_XOVF_BIT  = 6;
   localparam int unsigned HDR_YOVF_BIT  = 7;

   localparam logic [COORD_W-1:0] X_MAX_RESET = 10'd311;
   localparam logic [COORD_W-1:0] Y_MAX_RESET = 10'd187;
   localparam logic [COORD_W-1:0] POS_X_RESET = 10'd160;
   localparam logic [COORD_W-1:0] POS_Y_RESET = 10'd100;

   typedef struct packed {
      logic                      move;
      logic [1:0]                code;
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
   } cmd_type;

   typedef struct packed {
      logic [COORD_W-1:0] cursor_x;
      logic [COORD_W-1:0] cursor_y;
      logic               moved;
      logic [1:0]         byte_status;
   } rsp_type;

endpackage

>>> rtl/core/mpct_queue.sv
// ----------------------------------------------------------------------------
// mpct_queue
// Small show-ahead FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module mpct_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

>>> rtl/core/mpct_front.sv
// ----------------------------------------------------------------------------
// mpct_front
// Qualifies incoming words, assembles packets and issues one command per word.
// ----------------------------------------------------------------------------
module mpct_front
   import mpct_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic [7:0] status_byte,
   output cmd_type    cmd
);

   logic [1:0] byte_index_ff, byte_index_in;
   logic [7:0] header_ff, header_in;
   logic [7:0] x_delta_ff, x_delta_in;
   logic       counted;

   assign counted = status_byte[STS_FULL_BIT] && status_byte[STS_AUX_BIT];

   always_comb begin
      byte_index_in = byte_index_ff;
      header_in     = header_ff;
      x_delta_in    = x_delta_ff;
      cmd.move      = 1'b0;
      cmd.code      = STAT_IGNORED;
      cmd.dx        = $signed({header_ff[HDR_XSIGN_BIT], x_delta_ff});
      cmd.dy        = $signed({header_ff[HDR_YSIGN_BIT], data_byte});
      if (counted) begin
         case (byte_index_ff)
            IDX_HEADER: begin
               if (!data_byte[HDR_SYNC_BIT]) begin
                  cmd.code = STAT_HDR_REJECT;
               end else begin
                  header_in     = data_byte;
                  byte_index_in = IDX_XDELTA;
                  cmd.code      = STAT_ACCEPTED;
               end
            end
            IDX_XDELTA: begin
               x_delta_in    = data_byte;
               byte_index_in = IDX_YDELTA;
               cmd.code      = STAT_ACCEPTED;
            end
            default: begin
               // third byte (an index of three is handled the same way)
               byte_index_in = IDX_HEADER;
               if (header_ff[HDR_XOVF_BIT] || header_ff[HDR_YOVF_BIT]) begin
                  cmd.code = STAT_OVERFLOW;
               end else begin
                  cmd.move = 1'b1;
                  cmd.code = STAT_ACCEPTED;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= IDX_HEADER;
      end else if (accept) begin
         byte_index_ff <= byte_index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         header_ff  <= header_in;
         x_delta_ff <= x_delta_in;
      end
   end

endmodule

>>> rtl/core/mpct_back.sv
// ----------------------------------------------------------------------------
// mpct_back
// Executes commands: applies deltas, clamps the cursor and builds results.
// ----------------------------------------------------------------------------
`include "mouse_packet_cursor_tracker_macros.svh"

module mpct_back
   import mpct_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_en,
   input  logic               csr_index,
   input  logic [COORD_W-1:0] csr_wdata,
   input  logic               cmd_empty,
   input  cmd_type            cmd,
   output logic               cmd_pop,
   input  logic               rsp_full,
   output logic               rsp_push,
   output rsp_type            rsp
);

   logic [COORD_W-1:0]  x_max_ff, y_max_ff;
   logic [COORD_W-1:0]  pos_x_ff, pos_x_in;
   logic [COORD_W-1:0]  pos_y_ff, pos_y_in;
   logic signed [11:0]  sum_x, sum_y;

   function automatic logic [COORD_W-1:0] clamp_coord(input logic signed [11:0] v,
                                                      input logic [COORD_W-1:0] lim);
      logic [COORD_W-1:0] r;
      if (v[11]) begin
         r = '0;
      end else if (v[10:0] > {1'b0, lim}) begin
         r = lim;
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

   assign cmd_pop  = !cmd_empty && !rsp_full;
   assign rsp_push = cmd_pop;

   // x gains dx, y loses dy
   assign sum_x = $signed({2'b00, pos_x_ff}) + $signed({{3{cmd.dx[DELTA_W-1]}}, cmd.dx});
   assign sum_y = $signed({2'b00, pos_y_ff}) - $signed({{3{cmd.dy[DELTA_W-1]}}, cmd.dy});

   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      if (cmd.move) begin
         pos_x_in = clamp_coord(sum_x, x_max_ff);
         pos_y_in = clamp_coord(sum_y, y_max_ff);
      end
      rsp.cursor_x    = pos_x_in;
      rsp.cursor_y    = pos_y_in;
      rsp.moved       = cmd.move;
      rsp.byte_status = cmd.code;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_max_ff <= X_MAX_RESET;
         y_max_ff <= Y_MAX_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_X_MAX: x_max_ff <= csr_wdata;
            CSR_Y_MAX: y_max_ff <= csr_wdata;
            default:   x_max_ff <= x_max_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= POS_X_RESET;
         pos_y_ff <= POS_Y_RESET;
      end else if (cmd_pop) begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
      end
   end

   `MPCT_ASSERT_SAME(a_moved_is_accepted, clock, reset, rsp_push && rsp.moved, rsp.byte_status == STAT_ACCEPTED, "moved word without accepted status")
   `MPCT_ASSERT_NEXT(a_hold_without_move, clock, reset, cmd_pop && !cmd.move, $stable(pos_x_ff) && $stable(pos_y_ff), "cursor changed without a move")
   `MPCT_ASSERT_NEXT(a_move_within_limits, clock, reset, cmd_pop && cmd.move, (pos_x_ff <= $past(x_max_ff)) && (pos_y_ff <= $past(y_max_ff)), "cursor left its limits")

endmodule

>>> rtl/core/mouse_packet_cursor_tracker.sv
// ----------------------------------------------------------------------------
// mouse_packet_cursor_tracker
// Decodes mouse packets from controller reads and tracks a clamped cursor.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (data byte + status byte) enter through a queue-style port:
//   a word is taken when req_push is high and req_full is low.
//   Every input word yields exactly one result word, in order, on the rsp_
//   ports while rsp_empty is low; it is taken when rsp_pop is high.
//   rsp_empty falls once the word has passed the command queue into the
//   result queue; it can then be popped. One word per cycle is sustained
//   while results are popped; the front stage, a command queue, the
//   position update and a result queue each handle one word per cycle.
//   If the receiver stalls, the result queue fills, then the command queue,
//   and req_full rises; no word is lost and the stages restart on their own.
//   The csr_ port writes x_max (index 0) or y_max (index 1);
//   write only while no word is in flight.
//   Reset (synchronous) empties both queues, restarts packet assembly,
//   sets the cursor to 160,100 and the limits to 311,187.
// ----------------------------------------------------------------------------
module mouse_packet_cursor_tracker
   import mpct_pkg::*;
#(
   parameter int unsigned CMD_DEPTH = 2,
   parameter int unsigned RSP_DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  logic [7:0]   req_data_byte,
   input  logic [7:0]   req_status_byte,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output logic [9:0]   rsp_cursor_x,
   output logic [9:0]   rsp_cursor_y,
   output logic         rsp_moved,
   output logic [1:0]   rsp_byte_status,
   input  logic         csr_write_en,
   input  logic         csr_index,
   input  logic [9:0]   csr_wdata
);

   cmd_type cmd_wr, cmd_rd;
   rsp_type rsp_wr, rsp_rd;
   logic    accept;
   logic    cmd_empty, cmd_pop;
   logic    rsp_q_full, rsp_push;

   assign accept = req_push && !req_full;

   mpct_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_data_byte),
      .status_byte (req_status_byte),
      .cmd         (cmd_wr)
   );

   mpct_queue #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (cmd_wr),
      .full  (req_full),
      .pop   (cmd_pop),
      .rdata (cmd_rd),
      .empty (cmd_empty)
   );

   mpct_back u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd_empty    (cmd_empty),
      .cmd          (cmd_rd),
      .cmd_pop      (cmd_pop),
      .rsp_full     (rsp_q_full),
      .rsp_push     (rsp_push),
      .rsp          (rsp_wr)
   );

   mpct_queue #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_wr),
      .full  (rsp_q_full),
      .pop   (rsp_pop),
      .rdata (rsp_rd),
      .empty (rsp_empty)
   );

   assign rsp_cursor_x    = rsp_rd.cursor_x;
   assign rsp_cursor_y    = rsp_rd.cursor_y;
   assign rsp_moved       = rsp_rd.moved;
   assign rsp_byte_status = rsp_rd.byte_status;

endmodule
